### design/cds_pkg.sv
// Package for the conditional directive stack: opcodes, error codes,
// frame bit layout, stream packing widths and the default nesting limit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

    // Default nesting limit (number of stack frames)
    localparam int MAX_NEST_DEF = 32;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // Field widths
    localparam int OPCODE_W = 3;
    localparam int DEPTH_OUT_W = 6;
    localparam int ERR_W = 3;

    // Stack frame: bit0 saved active, bit1 saved else-allowed, bit2 branch taken
    localparam int FRAME_W = 3;
    localparam int FR_PROC = 0;
    localparam int FR_ELSE = 1;
    localparam int FR_TAKEN = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_IF     = 3'd0,
        OP_IFDEF  = 3'd1,
        OP_IFNDEF = 3'd2,
        OP_ELIF   = 3'd3,
        OP_ELSE   = 3'd4,
        OP_ENDIF  = 3'd5
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_TOO_DEEP = 3'd1,
        ERR_BAD_NAME = 3'd2,
        ERR_ELIF     = 3'd3,
        ERR_ELSE     = 3'd4,
        ERR_ENDIF    = 3'd5
    } err_t;

endpackage

`default_nettype wire

### design/cds_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cds_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/conditional_directive_stack.sv
// Top level of the conditional directive stack: stream ports, control FSM,
// read-modify-write of the frame stack. Uses cds_pkg and cds_ram.
// An accepted directive issues the top-of-stack read, is decoded in ST_EXEC and
// has its result registered on m_* once the result register is free. A new
// directive is taken only after the previous one has written its frame back.
// Reset (aresetn low, synchronous): depth 0, active 1, else-allowed 0, no
// result pending; stack RAM contents are not cleared and are read only after written.
`timescale 1ns / 1ps
`default_nettype none

module conditional_directive_stack #(
    parameter int MAX_NEST = cds_pkg::MAX_NEST_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [2:0] opcode, [3] cond_value, [4] name_defined, [5] name_valid
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cds_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: [0] active, [6:1] nest_depth, [9:7] error_code
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cds_pkg::M_TDATA_W-1:0]  m_tdata
);

    import cds_pkg::*;

    // Depth counter holds 0..MAX_NEST; RAM address covers 0..MAX_NEST-1
    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,  // wait for a directive
        ST_EXEC = 2'b10   // frame read data valid, update state
    } state_t;

    state_t state_reg, state_next;

    // Architectural state
    logic [DW-1:0] depth_reg, depth_next;
    logic          active_reg, active_next;
    logic          else_reg, else_next;

    // Captured directive
    logic [OPCODE_W-1:0] op_reg;
    logic                cond_reg;
    logic                defd_reg;
    logic                valid_reg;

    // Result register
    logic                   m_valid_reg;
    logic                   out_active_reg;
    logic [DEPTH_OUT_W-1:0] out_depth_reg;
    logic [ERR_W-1:0]       out_err_reg;

    // Stack RAM signals
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [FRAME_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      top_addr;
    logic [FRAME_W-1:0] frame;

    logic [DW-1:0]      depth_m1;
    logic               in_fire;
    logic               out_free;
    logic               exec_fire;
    logic               stack_full;
    logic               branch_open;
    logic               push_en;
    logic               push_cond;
    err_t               err;
    logic [DW+DEPTH_OUT_W-1:0] depth_ext;

    // Handshakes: take a directive only when idle; finish it when the
    // result register is empty or being drained this cycle.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    // Top-of-stack address; meaningless at depth 0, where the frame is unused
    assign depth_m1 = depth_reg - DW'(1);
    assign top_addr = depth_m1[AW-1:0];

    // Issue the top-of-stack read when the directive is accepted
    assign ram_re = in_fire;

    cds_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_NEST)
    ) u_stack (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (top_addr),
        .rdata (frame)
    );

    assign stack_full  = (depth_reg >= DW'(MAX_NEST));
    assign branch_open = else_reg && (depth_reg != '0);

    // Directive decode and state update (valid in ST_EXEC)
    always_comb begin
        depth_next  = depth_reg;
        active_next = active_reg;
        else_next   = else_reg;
        err         = ERR_OK;
        push_en     = 1'b0;
        push_cond   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = top_addr;
        ram_wdata   = frame;

        case (op_reg)
            OP_IF: begin
                if (stack_full) begin
                    err = ERR_TOO_DEEP;
                end else begin
                    push_en   = 1'b1;
                    push_cond = cond_reg;
                end
            end
            OP_IFDEF, OP_IFNDEF: begin
                // Depth is checked before the name
                if (stack_full) begin
                    err = ERR_TOO_DEEP;
                end else if (!valid_reg) begin
                    err = ERR_BAD_NAME;
                end else begin
                    push_en   = 1'b1;
                    push_cond = (op_reg == OP_IFDEF) ? defd_reg : !defd_reg;
                end
            end
            OP_ELIF: begin
                if (!branch_open) begin
                    err = ERR_ELIF;
                end else if (frame[FR_PROC] && !frame[FR_TAKEN]) begin
                    // Enclosing level live and no branch taken yet
                    active_next = cond_reg;
                    if (cond_reg) begin
                        ram_we    = 1'b1;
                        ram_wdata = frame | FRAME_W'(1 << FR_TAKEN);
                    end
                end else begin
                    active_next = 1'b0;
                end
            end
            OP_ELSE: begin
                if (!branch_open) begin
                    err = ERR_ELSE;
                end else begin
                    active_next = frame[FR_PROC] && !frame[FR_TAKEN];
                    else_next   = 1'b0;
                end
            end
            OP_ENDIF: begin
                if (depth_reg == '0) begin
                    err = ERR_ENDIF;
                end else begin
                    // Pop: restore the enclosing level's flags
                    depth_next  = depth_m1;
                    active_next = frame[FR_PROC];
                    else_next   = frame[FR_ELSE];
                end
            end
            default: begin
                // Unused opcodes: no state change, no error
            end
        endcase

        if (push_en) begin
            // Save the current level; a dead level pushes a dead frame
            ram_we      = 1'b1;
            ram_waddr   = depth_reg[AW-1:0];
            ram_wdata[FR_PROC]  = active_reg;
            ram_wdata[FR_ELSE]  = else_reg;
            ram_wdata[FR_TAKEN] = active_reg && push_cond;
            active_next = active_reg && push_cond;
            else_next   = 1'b1;
            depth_next  = depth_reg + DW'(1);
        end

        // Write back only when the result can be posted
        ram_we = ram_we && exec_fire;
    end

    // Next FSM state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Low bits of the new depth for the result field
    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_next};

    // Control and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            active_reg  <= 1'b1;
            else_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                depth_reg   <= depth_next;
                active_reg  <= active_next;
                else_reg    <= else_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                // Drop the result once the downstream takes it
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture the directive, hold the result
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg    <= s_tdata[2:0];
            cond_reg  <= s_tdata[3];
            defd_reg  <= s_tdata[4];
            valid_reg <= s_tdata[5];
        end
        if (exec_fire) begin
            out_active_reg <= active_next;
            out_depth_reg  <= depth_ext[DEPTH_OUT_W-1:0];
            out_err_reg    <= err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {
        {(M_TDATA_W - 1 - DEPTH_OUT_W - ERR_W){1'b0}},
        out_err_reg,
        out_depth_reg,
        out_active_reg
    };

endmodule

`default_nettype wire

### design/cds_checker.sv
// Port-level checker for conditional_directive_stack, with its bind.
// Uses cds_pkg for error codes.
`timescale 1ns / 1ps
`default_nettype none

module cds_checker #(
    parameter int MAX_NEST = cds_pkg::MAX_NEST_DEF
) (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire [cds_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [cds_pkg::M_TDATA_W-1:0]  m_tdata
);

    import cds_pkg::*;

    localparam logic [5:0] FULL_LOW = 6'(MAX_NEST % 64);

    // A held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One directive in flight: no accept in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second directive taken while one is in flight");

    // Error codes stay within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:7] <= ERR_ENDIF)
        else $error("undefined error code");

    // Depth never exceeds the nesting limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MAX_NEST > 63) || (m_tdata[6:1] <= FULL_LOW))
        else $error("depth beyond nesting limit");

    // An overflow is reported only at full depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:7] == ERR_TOO_DEEP) |-> m_tdata[6:1] == FULL_LOW)
        else $error("overflow reported below full depth");

endmodule

bind conditional_directive_stack cds_checker #(.MAX_NEST(MAX_NEST)) u_cds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for conditional_directive_stack: directed, nesting-limit,
// backpressure and random directive streams checked against an in-bench predictor.
// Depends on cds_pkg and the conditional_directive_stack RTL.
`timescale 1ns / 1ps

module tb_top;
    import cds_pkg::*;

    localparam int MAX_NEST    = MAX_NEST_DEF;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the pressure test
    localparam int IDLE_LIMIT  = 3000;  // cycles with no transaction before giving up
    localparam int RANDOM_ITEMS = 1150;

    typedef struct packed {
        logic                   active;
        logic [DEPTH_OUT_W-1:0] depth;
        logic [ERR_W-1:0]       err;
    } dir_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Predictor state: saved frames, depth and the current flags
    logic [FRAME_W-1:0] frame_stk [MAX_NEST];
    int                 pred_depth = 0;
    logic               pred_active = 1'b1;
    logic               pred_else_ok = 1'b0;

    dir_result_t pending_results [$];
    int          mismatch_cnt = 0;

    // Sender pacing and receiver hold-off control
    int burst_left = 0;
    bit steady_send = 1'b0;
    bit hold_req = 1'b0;
    int target_depth = 2;

    always #10 aclk = ~aclk;

    conditional_directive_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Advance the predicted state by one directive and return its result.
    function automatic dir_result_t predict_directive(logic [OPCODE_W-1:0] op, bit c, bit d,
                                                      bit v);
        dir_result_t        r;
        logic [FRAME_W-1:0] top;
        logic [FRAME_W-1:0] fr;
        bit                 branch_open;
        bit                 go;
        r.err = ERR_OK;
        branch_open = pred_else_ok && (pred_depth > 0);
        top = (pred_depth > 0) ? frame_stk[pred_depth-1] : '0;
        case (op)
            OP_IF, OP_IFDEF, OP_IFNDEF: begin
                go = (op == OP_IF) ? c : ((op == OP_IFDEF) ? d : !d);
                if (pred_depth >= MAX_NEST) begin
                    r.err = ERR_TOO_DEEP;
                end else if (op != OP_IF && !v) begin
                    r.err = ERR_BAD_NAME;
                end else begin
                    // save the enclosing level; an inactive level stays inactive
                    fr = '0;
                    fr[FR_PROC]  = pred_active;
                    fr[FR_ELSE]  = pred_else_ok;
                    fr[FR_TAKEN] = pred_active && go;
                    if (pred_active)
                        pred_active = go;
                    frame_stk[pred_depth] = fr;
                    pred_depth++;
                    pred_else_ok = 1'b1;
                end
            end
            OP_ELIF: begin
                if (!branch_open) begin
                    r.err = ERR_ELIF;
                end else if (top[FR_PROC] && !top[FR_TAKEN]) begin
                    if (c)
                        frame_stk[pred_depth-1][FR_TAKEN] = 1'b1;
                    pred_active = c;
                end else begin
                    pred_active = 1'b0;
                end
            end
            OP_ELSE: begin
                if (!branch_open) begin
                    r.err = ERR_ELSE;
                end else begin
                    pred_active = top[FR_PROC] && !top[FR_TAKEN];
                    pred_else_ok = 1'b0;
                end
            end
            OP_ENDIF: begin
                if (pred_depth == 0) begin
                    r.err = ERR_ENDIF;
                end else begin
                    pred_depth--;
                    pred_active = top[FR_PROC];
                    pred_else_ok = top[FR_ELSE];
                end
            end
            default: ;  // unused opcodes leave everything as is
        endcase
        r.active = pred_active;
        r.depth = DEPTH_OUT_W'(pred_depth);
        return r;
    endfunction

    // Offer one directive, hold it until accepted, then queue its prediction.
    task automatic send_directive(logic [OPCODE_W-1:0] op, bit c, bit d, bit v);
        int gap;
        @(negedge aclk);
        if (!steady_send && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
            @(negedge aclk);
        end
        s_tdata  <= {2'b00, v, d, c, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        pending_results.push_back(predict_directive(op, c, d, v));
    endtask

    // Pick a mostly well-formed directive from the current predicted state.
    task automatic choose_directive(output logic [OPCODE_W-1:0] op, output bit c,
                                    output bit d, output bit v);
        int pick;
        int push_pct;
        c = $urandom_range(0, 1);
        d = $urandom_range(0, 1);
        v = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 39) == 0)
            target_depth = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_NEST)
                                                      : $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 8) begin
            // noise: anything at all, unused opcodes included
            op = OPCODE_W'($urandom_range(0, 7));
            v = $urandom_range(0, 1);
        end else begin
            push_pct = (pred_depth < target_depth) ? 55 : 10;
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                op = OPCODE_W'($urandom_range(OP_IF, OP_IFNDEF));
            else if (pred_depth > 0 && pred_else_ok && pick < push_pct + 30)
                op = ($urandom_range(0, 2) != 0) ? OP_ELIF : OP_ELSE;
            else if (pred_depth > 0)
                op = OP_ENDIF;
            else
                op = OP_IF;
        end
    endtask

    // Error paths at depth zero, every opcode, names, inactive nesting.
    task automatic test_directed();
        send_directive(OP_ELIF,   1, 0, 1);   // stray elif
        send_directive(OP_ELSE,   0, 0, 1);   // stray else
        send_directive(OP_ENDIF,  0, 0, 1);   // endif with nothing open
        send_directive(3'd6,      1, 1, 1);   // unused opcode
        send_directive(OP_IF,     0, 0, 0);
        send_directive(OP_ELIF,   1, 0, 0);   // takes the branch
        send_directive(OP_ELIF,   1, 0, 0);   // branch already taken
        send_directive(OP_ELSE,   0, 0, 0);
        send_directive(OP_ELIF,   1, 1, 1);   // elif after else
        send_directive(OP_ELSE,   1, 1, 1);   // second else
        send_directive(OP_ENDIF,  0, 0, 0);
        send_directive(OP_IFDEF,  1, 1, 0);   // illegal name
        send_directive(OP_IFNDEF, 1, 0, 0);   // illegal name
        send_directive(OP_IFDEF,  0, 1, 1);
        send_directive(OP_IFNDEF, 0, 1, 1);   // goes inactive
        send_directive(OP_IF,     1, 0, 0);   // nested under an inactive level
        send_directive(OP_ELSE,   0, 0, 0);
        send_directive(OP_ENDIF,  0, 0, 0);
        send_directive(OP_ELSE,   0, 0, 0);
        send_directive(3'd7,      0, 0, 0);   // unused opcode
        send_directive(OP_ENDIF,  1, 1, 1);
        send_directive(OP_IFNDEF, 0, 0, 1);
        send_directive(OP_ENDIF,  0, 0, 0);
        send_directive(OP_ENDIF,  0, 0, 0);
    endtask

    // Fill the stack, push past the limit, then unwind one past empty.
    task automatic test_nest_limit();
        repeat (MAX_NEST)
            send_directive(OP_IF, $urandom_range(0, 1), 0, 0);
        send_directive(OP_IF,     1, 0, 1);
        send_directive(OP_IFDEF,  1, 1, 0);   // depth wins over the bad name
        send_directive(OP_IFNDEF, 0, 0, 1);
        send_directive(OP_ELIF,   1, 0, 0);
        send_directive(OP_ELSE,   0, 0, 0);
        repeat (MAX_NEST)
            send_directive(OP_ENDIF, 0, 0, 0);
        send_directive(OP_ENDIF, 0, 0, 0);
    endtask

    // Hold the receiver off while offering back to back so the input stalls.
    task automatic test_backpressure();
        logic [OPCODE_W-1:0] op;
        bit c, d, v;
        steady_send = 1'b1;
        hold_req = 1'b1;
        repeat (60) begin
            choose_directive(op, c, d, v);
            send_directive(op, c, d, v);
        end
        steady_send = 1'b0;
    endtask

    task automatic test_random();
        logic [OPCODE_W-1:0] op;
        bit c, d, v;
        repeat (RANDOM_ITEMS) begin
            choose_directive(op, c, d, v);
            send_directive(op, c, d, v);
        end
    endtask

    // Receiver: switch between always ready, random stalls and a sparse pattern;
    // a requested hold-off is counted here.
    initial begin : sink
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        dir_result_t want;
        dir_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.active = m_tdata[0];
            got.depth  = m_tdata[6:1];
            got.err    = m_tdata[9:7];
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.active !== want.active) begin
                    mismatch_cnt++;
                    $display("%0t: active expected %b actual %b", $time, want.active,
                             got.active);
                end
                if (got.depth !== want.depth) begin
                    mismatch_cnt++;
                    $display("%0t: nest_depth expected %0d actual %0d", $time, want.depth,
                             got.depth);
                end
                if (got.err !== want.err) begin
                    mismatch_cnt++;
                    $display("%0t: error_code expected %0d actual %0d", $time, want.err,
                             got.err);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transaction on either side.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_nest_limit();
        test_backpressure();
        test_random();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        // drain window: any extra result would show up here
        repeat (10) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
